[rtl/core/tile_id_to_quad_coords_unit_macros.svh]
// Assertion macros for the tile id to quad coordinates unit.
// Used by the top level only; no other dependencies.
`ifndef TILE_ID_TO_QUAD_COORDS_UNIT_MACROS_SVH
`define TILE_ID_TO_QUAD_COORDS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIDQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TIDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tidq_pkg.sv]
// Shared types, widths and helpers for the tile id to quad coordinates unit.
// No dependencies; imported by every module of the block.
package tidq_pkg;

	localparam int COORD_W    = 12;
	localparam int ID_W       = 16;
	localparam int TSIZE_W    = 9;
	localparam int LEVEL_W_W  = 13;
	localparam int CNT_REG_W  = 3;
	localparam int PACK_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int N_W        = 16;
	localparam int LOCAL_W    = 16;
	localparam int VB_W       = 26;
	localparam int SCR_W      = 21;
	localparam int TEX_W      = 25;
	localparam int TSEL_W     = 2;

	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 216;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_BITS    = 4;
	localparam int DIV_STAGES  = LOCAL_W / DIV_BITS;

	localparam int TIDQ_MAX_TILESETS  = 4;
	localparam int TIDQ_MAX_LEVEL_DIM = 4096;

	localparam logic [TSIZE_W-1:0]   RST_TILE_WIDTH  = 9'd16;
	localparam logic [TSIZE_W-1:0]   RST_TILE_HEIGHT = 9'd16;
	localparam logic [LEVEL_W_W-1:0] RST_LEVEL_WIDTH = 13'd64;
	localparam logic [CNT_REG_W-1:0] RST_TS_COUNT    = 3'd1;
	localparam logic [PACK_W-1:0]    RST_TS_COLUMNS  = 32'd1;
	localparam logic [PACK_W-1:0]    RST_TS_ROWS     = 32'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH  = 3'd0,
		REG_TILE_HEIGHT = 3'd1,
		REG_LEVEL_WIDTH = 3'd2,
		REG_TS_COUNT    = 3'd3,
		REG_TS_COLUMNS  = 3'd4,
		REG_TS_ROWS     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [TSIZE_W-1:0]   tile_width;
		logic [TSIZE_W-1:0]   tile_height;
		logic [LEVEL_W_W-1:0] level_width;
		logic [CNT_REG_W-1:0] tileset_count;
		logic [PACK_W-1:0]    tileset_columns;
		logic [PACK_W-1:0]    tileset_rows;
	} cfg_t;

	// One classified cell, handed from the front to the back.
	typedef struct packed {
		logic               drawn;
		logic               oor;
		logic [TSEL_W-1:0]  tsel;
		logic [LOCAL_W-1:0] local_idx;
		logic [BYTE_W-1:0]  cols;
		logic [VB_W-1:0]    vertex;
		logic [SCR_W-1:0]   scr_left;
		logic [SCR_W-1:0]   scr_top;
		logic [SCR_W-1:0]   scr_right;
		logic [SCR_W-1:0]   scr_bottom;
	} qitem_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	// Byte idx of a packed register; bytes past the fourth read as zero.
	function automatic logic [BYTE_W-1:0] packed_byte(logic [PACK_W-1:0] r, int idx);
		logic [PACK_W-1:0] sh;
		sh = (idx < PACK_W / BYTE_W) ? (r >> (BYTE_W * idx)) : '0;
		return sh[BYTE_W-1:0];
	endfunction

endpackage

[rtl/core/tile_id_to_quad_coords_unit.sv]
// Top level of the tile id to quad coordinates unit: configuration registers,
// front, queue and back. Depends on tidq_pkg, tidq_front, tidq_queue, tidq_back.
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+---------------------------------------
// s_*      | in  | s_tvalid/s_tready  | s_tdata: cell_x, cell_y, tile_id
// m_*      | out | m_tvalid/m_tready  | m_tdata: quad fields, m_tuser: flags
// cfg_*    | in  | cfg_we             | cfg_idx, cfg_wdata
//
// One cell per clock sustained while the output is not stalled; from an input
// transaction to the earliest output transaction a cell passes two front stages,
// the queue, four divider stages (four quotient bits each), a multiply stage and
// the output register.
// Reset clears the handshake state and loads the default configuration.
// A stalled output holds the back end; the four-entry queue keeps the front
// accepting until it fills.
`include "tile_id_to_quad_coords_unit_macros.svh"

module tile_id_to_quad_coords_unit import tidq_pkg::*; #(
	parameter int MAX_TILESETS  = TIDQ_MAX_TILESETS,
	parameter int MAX_LEVEL_DIM = TIDQ_MAX_LEVEL_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cell_x [11:0], cell_y [23:12], tile_id [39:24]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tileset_index [1:0], vertex_base [27:2], screen_left [48:28],
	// screen_top [69:49], screen_right [90:70], screen_bottom [111:91],
	// texture_left [136:112], texture_top [161:137],
	// texture_right [186:162], texture_bottom [211:187]
	output logic [M_TDATA_W-1:0]  m_tdata,
	// drawn [0], out_of_range [1]
	output logic [M_TUSER_W-1:0]  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	logic    q_push, q_pop;
	qitem_t  q_in, q_out;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_width      <= RST_TILE_WIDTH;
			cfg_q.tile_height     <= RST_TILE_HEIGHT;
			cfg_q.level_width     <= RST_LEVEL_WIDTH;
			cfg_q.tileset_count   <= RST_TS_COUNT;
			cfg_q.tileset_columns <= RST_TS_COLUMNS;
			cfg_q.tileset_rows    <= RST_TS_ROWS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TILE_WIDTH:  cfg_q.tile_width      <= cfg_wdata[TSIZE_W-1:0];
				REG_TILE_HEIGHT: cfg_q.tile_height     <= cfg_wdata[TSIZE_W-1:0];
				REG_LEVEL_WIDTH: cfg_q.level_width     <= cfg_wdata[LEVEL_W_W-1:0];
				REG_TS_COUNT:    cfg_q.tileset_count   <= cfg_wdata[CNT_REG_W-1:0];
				REG_TS_COLUMNS:  cfg_q.tileset_columns <= cfg_wdata[PACK_W-1:0];
				REG_TS_ROWS:     cfg_q.tileset_rows    <= cfg_wdata[PACK_W-1:0];
				default: ;
			endcase
		end
	end

	tidq_front #(
		.MAX_TILESETS  (MAX_TILESETS),
		.MAX_LEVEL_DIM (MAX_LEVEL_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_stat.full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	tidq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.pop_item  (q_out),
		.stat      (q_stat)
	);

	tidq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (!q_stat.empty),
		.q_item   (q_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`TIDQ_ASSERT_IMPLY(a_empty_cell_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0 && !m_tuser[1], "empty cell result carries nonzero fields")
	`TIDQ_ASSERT_IMPLY(a_oor_needs_drawn, clk, arst_n, m_tvalid && m_tuser[1], m_tuser[0], "out_of_range set on an empty cell")
	`TIDQ_ASSERT_IMPLY(a_queue_bound, clk, arst_n, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH) && !(q_pop && q_stat.empty), "queue overflow or pop from empty")
	`TIDQ_ASSERT_NEXT(a_queue_fill, clk, arst_n, q_push && q_stat.empty, !q_stat.empty, "pushed entry lost from empty queue")

endmodule

[rtl/core/tidq_front.sv]
// Front end: accepts cells, finds the tileset and local index, screen rect.
// Depends on tidq_pkg; feeds tidq_queue.
module tidq_front import tidq_pkg::*; #(
	parameter int MAX_TILESETS  = TIDQ_MAX_TILESETS,
	parameter int MAX_LEVEL_DIM = TIDQ_MAX_LEVEL_DIM
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 q_full,
	output logic                 q_push,
	output qitem_t               q_item
);

	localparam int ACC_W   = N_W + $clog2(MAX_TILESETS);
	localparam int CNT_W   = $clog2(MAX_TILESETS + 1);
	localparam int SEL_W   = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;
	localparam int LW_FULL = $clog2(MAX_LEVEL_DIM + 1);
	localparam int LW_W    = (LW_FULL < LEVEL_W_W) ? LW_FULL : LEVEL_W_W;
	localparam int YLW_W   = COORD_W + LW_W;

	logic                 adv;
	logic [COORD_W-1:0]   x_in, y_in;
	logic [ID_W-1:0]      id_in;
	logic [LW_W-1:0]      lw_sat;

	logic                 v_s1;
	logic [COORD_W-1:0]   x_s1, y_s1;
	logic [ID_W-1:0]      id_s1;
	logic [N_W-1:0]       n_s1 [MAX_TILESETS];
	logic [SCR_W-1:0]     xtw_s1, yth_s1;
	logic [YLW_W-1:0]     ylw_s1;

	logic                 v_s2;
	qitem_t               item_s2;
	qitem_t               item_d;

	logic [CNT_W-1:0]     cnt;
	logic [ACC_W-1:0]     acc;
	logic [ACC_W:0]       upper;
	logic [ACC_W:0]       loc_wide;
	logic [SEL_W-1:0]     sel;
	logic [BYTE_W-1:0]    cols;
	logic                 found;
	logic [VB_W-1:0]      vsum;

	assign x_in  = s_tdata[COORD_W-1:0];
	assign y_in  = s_tdata[2*COORD_W-1:COORD_W];
	assign id_in = s_tdata[2*COORD_W+ID_W-1:2*COORD_W];

	assign adv      = !v_s2 || !q_full;
	assign s_tready = adv;
	assign q_push   = v_s2 && !q_full;
	assign q_item   = item_s2;

	always_comb begin
		if (17'(cfg.level_width) > 17'(MAX_LEVEL_DIM))
			lw_sat = LW_W'(MAX_LEVEL_DIM);
		else
			lw_sat = LW_W'(cfg.level_width);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			id_s1  <= id_in;
			xtw_s1 <= SCR_W'(x_in) * SCR_W'(cfg.tile_width);
			yth_s1 <= SCR_W'(y_in) * SCR_W'(cfg.tile_height);
			ylw_s1 <= YLW_W'(y_in) * YLW_W'(lw_sat);
			for (int i = 0; i < MAX_TILESETS; i++)
				n_s1[i] <= N_W'(packed_byte(cfg.tileset_columns, i)) *
					N_W'(packed_byte(cfg.tileset_rows, i));
			item_s2 <= item_d;
		end
	end

	// Walk the tilesets in order; stop at the first whose range holds the id.
	always_comb begin
		if (cfg.tileset_count == '0)
			cnt = CNT_W'(1);
		else if (4'(cfg.tileset_count) > 4'(MAX_TILESETS))
			cnt = CNT_W'(MAX_TILESETS);
		else
			cnt = CNT_W'(cfg.tileset_count);

		found = 1'b0;
		acc   = '0;
		sel   = '0;
		cols  = '0;
		upper = '0;
		for (int i = 0; i < MAX_TILESETS; i++) begin
			if (!found && (CNT_W'(i) < cnt)) begin
				sel   = SEL_W'(i);
				cols  = packed_byte(cfg.tileset_columns, i);
				upper = (ACC_W+1)'(acc) + (ACC_W+1)'(n_s1[i]);
				if ((ACC_W+1)'(id_s1) <= upper)
					found = 1'b1;
				else
					acc = upper[ACC_W-1:0];
			end
		end
		if (cols == '0)
			cols = BYTE_W'(1);

		loc_wide = (ACC_W+1)'(id_s1) - (ACC_W+1)'(acc) - (ACC_W+1)'(1);
		vsum     = VB_W'(ylw_s1) + VB_W'(x_s1);

		item_d.drawn      = (id_s1 != '0);
		item_d.oor        = !found;
		item_d.tsel       = TSEL_W'(sel);
		item_d.local_idx  = loc_wide[LOCAL_W-1:0];
		item_d.cols       = cols;
		item_d.vertex     = vsum << 2;
		item_d.scr_left   = xtw_s1;
		item_d.scr_top    = yth_s1;
		item_d.scr_right  = xtw_s1 + SCR_W'(cfg.tile_width);
		item_d.scr_bottom = yth_s1 + SCR_W'(cfg.tile_height);
	end

endmodule

[rtl/core/tidq_queue.sv]
// Short queue between front and back so each side stalls on its own.
// Depends on tidq_pkg for the item type and depth.
module tidq_queue import tidq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qitem_t  push_item,
	input  logic    pop,
	output qitem_t  pop_item,
	output q_stat_t stat
);

	qitem_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign pop_item   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/tidq_back.sv]
// Back end: splits the local index by the column count (pipelined divider),
// scales to texture coordinates and holds the result. Depends on tidq_pkg.
module tidq_back import tidq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 q_valid,
	input  qitem_t               q_item,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser
);

	typedef struct packed {
		qitem_t             item;
		logic [BYTE_W-1:0]  rem;
		logic [LOCAL_W-1:0] quo;
	} div_t;

	logic                 adv;
	div_t                 entry;
	logic                 dv_s [DIV_STAGES];
	div_t                 dd_s [DIV_STAGES];
	logic                 mv_s;
	qitem_t               mitem_s;
	logic [TEX_W-1:0]     tl_s, tt_s;
	logic                 out_v_q;
	logic [M_TDATA_W-1:0] tdata_q, tdata_d;
	logic [M_TUSER_W-1:0] tuser_q, tuser_d;
	logic [TEX_W-1:0]     tr, tb;

	// Restoring division, DIV_BITS quotient bits per stage.
	function automatic div_t div_step(div_t a);
		div_t            r;
		logic [BYTE_W:0] t;
		r = a;
		for (int b = 0; b < DIV_BITS; b++) begin
			t = {r.rem, r.quo[LOCAL_W-1]};
			if (t >= {1'b0, r.item.cols}) begin
				r.rem = BYTE_W'(t - {1'b0, r.item.cols});
				r.quo = {r.quo[LOCAL_W-2:0], 1'b1};
			end else begin
				r.rem = t[BYTE_W-1:0];
				r.quo = {r.quo[LOCAL_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign adv      = !out_v_q || m_tready;
	assign q_pop    = adv && q_valid;
	assign m_tvalid = out_v_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	always_comb begin
		entry.item = q_item;
		entry.rem  = '0;
		entry.quo  = q_item.local_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				dv_s[k] <= 1'b0;
			mv_s    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= q_valid;
			for (int k = 1; k < DIV_STAGES; k++)
				dv_s[k] <= dv_s[k-1];
			mv_s    <= dv_s[DIV_STAGES-1];
			out_v_q <= mv_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s[0] <= div_step(entry);
			for (int k = 1; k < DIV_STAGES; k++)
				dd_s[k] <= div_step(dd_s[k-1]);
			mitem_s <= dd_s[DIV_STAGES-1].item;
			tl_s    <= TEX_W'(dd_s[DIV_STAGES-1].rem) * TEX_W'(cfg.tile_width);
			tt_s    <= TEX_W'(dd_s[DIV_STAGES-1].quo) * TEX_W'(cfg.tile_height);
			tdata_q <= tdata_d;
			tuser_q <= tuser_d;
		end
	end

	// Empty cells leave every field at zero.
	always_comb begin
		tr = tl_s + TEX_W'(cfg.tile_width);
		tb = tt_s + TEX_W'(cfg.tile_height);
		if (mitem_s.drawn) begin
			tdata_d = {4'b0, tb, tr, tt_s, tl_s,
				mitem_s.scr_bottom, mitem_s.scr_right, mitem_s.scr_top,
				mitem_s.scr_left, mitem_s.vertex, mitem_s.tsel};
			tuser_d = {mitem_s.oor, 1'b1};
		end else begin
			tdata_d = '0;
			tuser_d = '0;
		end
	end

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for tile_id_to_quad_coords_unit: streams map cells in,
// predicts each quad in tb_top and compares it field by field on the output side.
// Depends on tidq_pkg and the unit's RTL only.
module tb_top import tidq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          QUAD_CORNERS = 4;
	localparam int          LONG_HOLD    = 300;
	localparam int          DRAIN_CYCLES = 12;
	localparam int unsigned RUN_LIMIT    = 1000000;
	localparam int          SETTLE_CASES = 8;
	localparam int          CELLS_PER    = 182;

	// Packed so that cell_x lands in the low bits of s_tdata.
	typedef struct packed {
		logic [ID_W-1:0]    tile_id;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_x;
	} cell_t;

	typedef struct packed {
		logic              drawn;
		logic              oor;
		logic [TSEL_W-1:0] tsel;
		logic [VB_W-1:0]   vertex;
		logic [SCR_W-1:0]  scr_left;
		logic [SCR_W-1:0]  scr_top;
		logic [SCR_W-1:0]  scr_right;
		logic [SCR_W-1:0]  scr_bottom;
		logic [TEX_W-1:0]  tex_left;
		logic [TEX_W-1:0]  tex_top;
		logic [TEX_W-1:0]  tex_right;
		logic [TEX_W-1:0]  tex_bottom;
	} quad_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Local copy of the register file.
	logic [TSIZE_W-1:0]   cfg_tile_w  = RST_TILE_WIDTH;
	logic [TSIZE_W-1:0]   cfg_tile_h  = RST_TILE_HEIGHT;
	logic [LEVEL_W_W-1:0] cfg_level_w = RST_LEVEL_WIDTH;
	logic [CNT_REG_W-1:0] cfg_sets    = RST_TS_COUNT;
	logic [PACK_W-1:0]    cfg_cols    = RST_TS_COLUMNS;
	logic [PACK_W-1:0]    cfg_rows    = RST_TS_ROWS;

	cell_t       cell_queue[$];
	quad_t       pending_quads[$];
	quad_t       seen_quad;
	quad_t       want_quad;
	int unsigned fault_count     = 0;
	int unsigned cycle_count     = 0;
	int unsigned src_gap         = 0;
	int unsigned sink_wait       = 0;
	bit          src_idle_on     = 1'b1;
	bit          sink_idle_on    = 1'b1;
	bit          long_hold_req   = 1'b0;
	bit          long_hold_taken = 1'b0;

	tile_id_to_quad_coords_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial forever #1 clk = ~clk;

	function automatic quad_t resolve_cell(cell_t item);
		quad_t           q;
		longint unsigned x, y, id, lw, acc, span, cols, offs, tu, tv, n_sets;
		int unsigned     sel;
		bit              hit;
		q = '0;
		if (item.tile_id == '0)
			return q;
		x = item.cell_x;
		y = item.cell_y;
		id = item.tile_id;
		n_sets = cfg_sets;
		if (n_sets < 1)
			n_sets = 1;
		if (n_sets > TIDQ_MAX_TILESETS)
			n_sets = TIDQ_MAX_TILESETS;
		lw = cfg_level_w;
		if (lw > TIDQ_MAX_LEVEL_DIM)
			lw = TIDQ_MAX_LEVEL_DIM;
		acc = 0;
		cols = 1;
		sel = 0;
		hit = 1'b0;
		// Walk the tilesets in order; an id past all of them stays on the last one.
		for (int k = 0; k < n_sets; k++) begin
			span = cfg_cols[BYTE_W*k +: BYTE_W] * cfg_rows[BYTE_W*k +: BYTE_W];
			sel = k;
			cols = cfg_cols[BYTE_W*k +: BYTE_W];
			if (id <= acc + span) begin
				hit = 1'b1;
				break;
			end
			acc += span;
		end
		if (cols == 0)
			cols = 1;
		offs = id - acc - 1;
		tu = offs % cols;
		tv = offs / cols;
		q.drawn      = 1'b1;
		q.oor        = !hit;
		q.tsel       = sel[TSEL_W-1:0];
		q.vertex     = VB_W'((x + y * lw) * QUAD_CORNERS);
		q.scr_left   = SCR_W'(x * cfg_tile_w);
		q.scr_top    = SCR_W'(y * cfg_tile_h);
		q.scr_right  = SCR_W'((x + 1) * cfg_tile_w);
		q.scr_bottom = SCR_W'((y + 1) * cfg_tile_h);
		q.tex_left   = TEX_W'(tu * cfg_tile_w);
		q.tex_top    = TEX_W'(tv * cfg_tile_h);
		q.tex_right  = TEX_W'((tu + 1) * cfg_tile_w);
		q.tex_bottom = TEX_W'((tv + 1) * cfg_tile_h);
		return q;
	endfunction

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [COORD_W-1:0] random_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return COORD_W'($urandom());
	endfunction

	function automatic cell_t random_cell();
		cell_t           item;
		longint unsigned edges[TIDQ_MAX_TILESETS+1];
		longint unsigned pick;
		int unsigned     n_sets, r;
		n_sets = (cfg_sets == 0) ? 1 : (cfg_sets > TIDQ_MAX_TILESETS) ? TIDQ_MAX_TILESETS
			: cfg_sets;
		edges[0] = 0;
		for (int k = 0; k < n_sets; k++)
			edges[k+1] = edges[k] + cfg_cols[BYTE_W*k +: BYTE_W] * cfg_rows[BYTE_W*k +: BYTE_W];
		r = $urandom_range(0, 19);
		if (r == 0)
			pick = 0;
		else if (r < 4)
			pick = $urandom_range(0, 65535);
		else if (r < 11)
			// land on a tileset boundary or just past it
			pick = edges[$urandom_range(0, n_sets)] + $urandom_range(0, 1);
		else if (edges[n_sets] == 0)
			pick = $urandom_range(1, 8);
		else
			pick = $urandom_range(1, (edges[n_sets] > 65535) ? 65535 : 32'(edges[n_sets]) + 2);
		if (pick > 65535)
			pick = 65535 - $urandom_range(0, 3);
		item.cell_x = random_coord();
		item.cell_y = random_coord();
		item.tile_id = ID_W'(pick);
		return item;
	endfunction

	function automatic logic [TSIZE_W-1:0] random_tile_size();
		int unsigned r;
		r = $urandom_range(0, 7);
		case (r)
			0: return '0;
			1: return 9'd1;
			2: return '1;
			3: return 9'd256;
			default: return TSIZE_W'($urandom_range(1, 511));
		endcase
	endfunction

	function automatic logic [PACK_W-1:0] random_counts();
		logic [PACK_W-1:0] packed_val;
		int unsigned       r;
		for (int k = 0; k < TIDQ_MAX_TILESETS; k++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				packed_val[BYTE_W*k +: BYTE_W] = '0;
			else if (r == 1)
				packed_val[BYTE_W*k +: BYTE_W] = '1;
			else if (r < 4)
				packed_val[BYTE_W*k +: BYTE_W] = BYTE_W'($urandom());
			else
				packed_val[BYTE_W*k +: BYTE_W] = BYTE_W'($urandom_range(1, 12));
		end
		return packed_val;
	endfunction

	// Fill the unused upper bits with noise half of the time.
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] value, int width);
		logic [CFG_DATA_W-1:0] hi;
		hi = $urandom_range(0, 1) ? ($urandom() << width) : '0;
		return hi | value;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TILE_WIDTH:  cfg_tile_w  = value[TSIZE_W-1:0];
			REG_TILE_HEIGHT: cfg_tile_h  = value[TSIZE_W-1:0];
			REG_LEVEL_WIDTH: cfg_level_w = value[LEVEL_W_W-1:0];
			REG_TS_COUNT:    cfg_sets    = value[CNT_REG_W-1:0];
			REG_TS_COLUMNS:  cfg_cols    = value;
			REG_TS_ROWS:     cfg_rows    = value;
			default: ;
		endcase
	endtask

	task automatic setup_tiles(logic [TSIZE_W-1:0] tw, th, logic [LEVEL_W_W-1:0] lw,
			logic [CNT_REG_W-1:0] sets, logic [PACK_W-1:0] cols, rows);
		write_reg(REG_TILE_WIDTH, with_junk(tw, TSIZE_W));
		write_reg(REG_TILE_HEIGHT, with_junk(th, TSIZE_W));
		write_reg(REG_LEVEL_WIDTH, with_junk(lw, LEVEL_W_W));
		write_reg(REG_TS_COUNT, with_junk(sets, CNT_REG_W));
		write_reg(REG_TS_COLUMNS, cols);
		write_reg(REG_TS_ROWS, rows);
	endtask

	task automatic push_cell(logic [COORD_W-1:0] x, y, logic [ID_W-1:0] id);
		cell_queue.insert(cell_queue.size(), cell_t'{tile_id: id, cell_y: y, cell_x: x});
	endtask

	// Hold until every cell went in and every quad came out, then let the pipe settle.
	task automatic wait_drained();
		while (cell_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_quads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			fault_count++;
			if (fault_count <= 10)
				$display("field %s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// Cell source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_quads.insert(pending_quads.size(), resolve_cell(cell_t'(s_tdata)));
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (cell_queue.size() > 0) begin
					s_tdata  <= cell_queue.pop_front();
					s_tvalid <= 1'b1;
					src_gap = (src_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Quad sink and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_quad.drawn      = m_tuser[0];
				seen_quad.oor        = m_tuser[1];
				seen_quad.tsel       = m_tdata[1:0];
				seen_quad.vertex     = m_tdata[27:2];
				seen_quad.scr_left   = m_tdata[48:28];
				seen_quad.scr_top    = m_tdata[69:49];
				seen_quad.scr_right  = m_tdata[90:70];
				seen_quad.scr_bottom = m_tdata[111:91];
				seen_quad.tex_left   = m_tdata[136:112];
				seen_quad.tex_top    = m_tdata[161:137];
				seen_quad.tex_right  = m_tdata[186:162];
				seen_quad.tex_bottom = m_tdata[211:187];
				if (pending_quads.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("quad with no cell pending: tdata 0x%0h tuser 0x%0h",
							m_tdata, m_tuser);
				end else begin
					want_quad = pending_quads.pop_front();
					check_field("drawn", want_quad.drawn, seen_quad.drawn);
					check_field("out_of_range", want_quad.oor, seen_quad.oor);
					check_field("tileset_index", want_quad.tsel, seen_quad.tsel);
					check_field("vertex_base", want_quad.vertex, seen_quad.vertex);
					check_field("screen_left", want_quad.scr_left, seen_quad.scr_left);
					check_field("screen_top", want_quad.scr_top, seen_quad.scr_top);
					check_field("screen_right", want_quad.scr_right, seen_quad.scr_right);
					check_field("screen_bottom", want_quad.scr_bottom, seen_quad.scr_bottom);
					check_field("texture_left", want_quad.tex_left, seen_quad.tex_left);
					check_field("texture_top", want_quad.tex_top, seen_quad.tex_top);
					check_field("texture_right", want_quad.tex_right, seen_quad.tex_right);
					check_field("texture_bottom", want_quad.tex_bottom, seen_quad.tex_bottom);
				end
			end
			if (long_hold_req && !long_hold_taken) begin
				long_hold_taken = 1'b1;
				sink_wait = LONG_HOLD;
			end
			if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				sink_wait = idle_length() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tile_id_to_quad_coords_unit: mismatch");
			$finish;
		end
	end

	initial begin
		logic [LEVEL_W_W-1:0] lw;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setup: one tileset holding a single tile.
		push_cell(12'd4095, 12'd4095, 16'd0);
		push_cell(12'd0, 12'd0, 16'd1);
		push_cell(12'd4095, 12'd4095, 16'd2);
		push_cell(12'd4095, 12'd0, 16'hFFFF);
		push_cell(12'd0, 12'd4095, 16'd1);
		wait_drained();

		// Three tilesets, the last with no columns; level width saturates.
		setup_tiles(9'd511, 9'd1, 13'd8191, 3'd3, 32'h0A000403, 32'h02050302);
		push_cell(12'd4095, 12'd4095, 16'd1);
		push_cell(12'd1, 12'd2, 16'd6);
		push_cell(12'd4095, 12'd0, 16'd7);
		push_cell(12'd0, 12'd4095, 16'd18);
		push_cell(12'd17, 12'd33, 16'd19);
		push_cell(12'd100, 12'd200, 16'd40);
		push_cell(12'd4095, 12'd4095, 16'hFFFF);
		push_cell(12'd5, 12'd5, 16'd0);
		wait_drained();

		// Count of zero reads as one; bytes past the count are ignored.
		setup_tiles(9'd1, 9'd511, 13'd0, 3'd0, 32'h030201FF, 32'h040302FF);
		push_cell(12'd0, 12'd0, 16'd1);
		push_cell(12'd4095, 12'd1, 16'd255);
		push_cell(12'd3, 12'd4095, 16'd256);
		push_cell(12'd2048, 12'd2048, 16'd65025);
		push_cell(12'd4095, 12'd4095, 16'd65026);
		push_cell(12'd1, 12'd1, 16'hFFFF);
		wait_drained();

		// Count above the limit clamps to four full tilesets.
		setup_tiles(9'd256, 9'd256, 13'd4096, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_cell(12'd4095, 12'd4095, 16'd1);
		push_cell(12'd4095, 12'd4095, 16'd65025);
		push_cell(12'd0, 12'd0, 16'd65026);
		push_cell(12'd4095, 12'd4095, 16'hFFFF);
		wait_drained();

		for (int ph = 0; ph < SETTLE_CASES; ph++) begin
			case ($urandom_range(0, 5))
				0: lw = '0;
				1: lw = 13'd1;
				2: lw = 13'd4096;
				3: lw = '1;
				default: lw = LEVEL_W_W'($urandom());
			endcase
			setup_tiles(random_tile_size(), random_tile_size(), lw,
				CNT_REG_W'($urandom_range(0, 7)), random_counts(), random_counts());
			src_idle_on  = (ph % 3) != 1;
			sink_idle_on = src_idle_on;
			if (ph == 3) begin
				// Back-to-back cells against a long-stalled sink: fill the unit.
				src_idle_on   = 1'b0;
				sink_idle_on  = 1'b0;
				long_hold_req = 1'b1;
			end
			repeat (CELLS_PER) cell_queue.insert(cell_queue.size(), random_cell());
			wait_drained();
		end

		if (fault_count == 0)
			$display("tile_id_to_quad_coords_unit: match");
		else
			$display("tile_id_to_quad_coords_unit: mismatch");
		$finish;
	end

endmodule
